[sv/lbbc_pkg.sv]
`default_nettype none

package lbbc_pkg;

   // field widths of the words on the ports
   localparam int OP_W       = 2;
   localparam int KEY_W      = 48;
   localparam int BYTES_W    = 34;
   localparam int CAP_W      = 38;
   localparam int CNT_W      = 32;
   localparam int EVN_W      = 5;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 144;

   // bytes in use: budget plus one slab at most, one bit of headroom over the budget
   localparam int USED_W     = 39;

   localparam logic [CAP_W-1:0] CAP_RESET = 38'd268435456;

   // operation codes carried on req_tuser
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_DECODE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
   localparam logic [OP_W-1:0] OP_STATS  = 2'd3;

   // kinds of table sweep
   localparam logic [1:0] MODE_SCAN = 2'd0;  // key search, free slot, oldest slot
   localparam logic [1:0] MODE_HIT  = 2'd1;  // promote hit entry, age the younger ones
   localparam logic [1:0] MODE_INS  = 2'd2;  // age all entries, write the new one
   localparam logic [1:0] MODE_FIND = 2'd3;  // locate the oldest entry

   typedef struct packed {
      logic [15:0] tensor;
      logic [15:0] start;
      logic [15:0] count;
   } key_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       target;   // row under work is the hit, free or evicted slot
   } row_ctrl_type;

   typedef struct packed {
      logic match;     // valid row with the requested key
      logic oldest;    // valid row holding the greatest age
      logic wr_en;     // row gets written back
      logic use_new;   // write back the new entry instead of the old row
   } row_stat_type;

endpackage

`default_nettype wire

[sv/lbbc_ram.sv]
`default_nettype none

module lbbc_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[sv/lbbc_row_unit.sv]
`default_nettype none

module lbbc_row_unit
   import lbbc_pkg::*;
#(
   parameter int AgeW = 4
) (
   input  logic         row_valid,
   input  key_type      row_key,
   input  logic [AgeW-1:0] row_age,
   input  key_type      req_key,
   input  logic [AgeW-1:0] ref_age,
   input  logic [AgeW-1:0] top_age,
   input  row_ctrl_type ctrl,
   output row_stat_type stat,
   output logic [AgeW-1:0] new_age
);

   logic older;

   // compare the row against the reference age
   assign older = row_valid && (row_age < ref_age);

   // compare the row against the request, pick the write back and the new age
   always_comb begin
      stat.match   = row_valid && (row_key == req_key);
      stat.oldest  = row_valid && (row_age == top_age);
      stat.wr_en   = 1'b0;
      stat.use_new = 1'b0;
      new_age      = row_age;
      unique case (ctrl.mode)
         MODE_HIT: begin
            stat.wr_en = row_valid;
            if (ctrl.target) begin
               new_age = '0;
            end else if (older) begin
               new_age = AgeW'(row_age + 1'b1);
            end
         end
         MODE_INS: begin
            stat.wr_en   = row_valid || ctrl.target;
            stat.use_new = ctrl.target;
            new_age      = ctrl.target ? '0 : AgeW'(row_age + 1'b1);
         end
         MODE_SCAN, MODE_FIND: begin
            stat.wr_en = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

[sv/lru_byte_budget_cache.sv]
// LRU slab cache with a byte budget.
// Request channel (req_*): one word per operation; req_tuser carries the op
// (lookup-insert, decode without reuse, clear table, reset counters) and
// req_tdata the key and row count. Response channel (rsp_*): exactly one word
// per request with the hit flag, evictions of this request, bytes in use and
// the three running counters. csr_wen/csr_wdata write the byte budget; write
// it only while no request is in flight. A lowered budget is applied at the
// next insert.
// The table lives in one RAM row per slot and every table operation is made
// of sweeps through that RAM, one row per cycle, with one shared compare/age
// unit. A hit runs a scan sweep and then a promote sweep before the response
// word, a miss a scan sweep, an insert sweep and a find sweep for each entry
// evicted to meet the budget; decode, clear and counter reset go straight to
// the response. req_tready is high only between requests.
// A finished word waits in the response register while the next request is
// accepted; a request finishing while that register is still stalled waits
// for rsp_tready. Reset empties the table, zeroes bytes in use and counters,
// and restores the budget to 256 MiB; the RAM needs no clearing.

`default_nettype none

module lru_byte_budget_cache
   import lbbc_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // budget register write
   input  logic                  csr_wen,
   input  logic [CAP_W-1:0]      csr_wdata,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tensor_id[15:0], first_col[31:16], num_cols[47:32], row_count[63:48]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // op[1:0]
   input  logic [OP_W-1:0]       req_tuser,
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // hit[0], evicted_now[5:1], bytes_in_use[43:6], hit_total[75:44],
   // miss_total[107:76], eviction_total[139:108], zero[143:140]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IdxW = $clog2(SLOTS);
   localparam int CntW = $clog2(SLOTS + 1);
   localparam int RowW = KEY_W + IdxW + BYTES_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PASS  = 2'd1;
   localparam logic [1:0] ST_CHECK = 2'd2;
   localparam logic [1:0] ST_FIN   = 2'd3;

   // control state
   logic [1:0]       state_ff, state_in;
   logic [1:0]       mode_ff, mode_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             p_vld_ff, p_vld_in;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [CntW-1:0]  n_ff, n_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [USED_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] hits_ff, hits_in;
   logic [CNT_W-1:0] misses_ff, misses_in;
   logic [CNT_W-1:0] evs_ff, evs_in;
   logic             rsp_vld_ff, rsp_vld_in;

   // per-request working registers
   logic [IdxW-1:0]    p_idx_ff, p_idx_in;
   key_type            key_ff, key_in;
   logic [BYTES_W-1:0] new_bytes_ff, new_bytes_in;
   logic               hit_ff, hit_in;
   logic [CntW-1:0]    ev_now_ff, ev_now_in;
   logic               found_ff, found_in;
   logic               free_seen_ff, free_seen_in;
   logic [IdxW-1:0]    free_idx_ff, free_idx_in;
   logic [IdxW-1:0]    tgt_idx_ff, tgt_idx_in;
   logic [IdxW-1:0]    ref_age_ff, ref_age_in;
   logic [IdxW-1:0]    old_idx_ff, old_idx_in;
   logic [BYTES_W-1:0] old_bytes_ff, old_bytes_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // RAM and row unit wiring
   logic               rd_en;
   logic [RowW-1:0]    rd_data;
   logic               ram_we;
   logic [RowW-1:0]    wr_data;
   key_type            rd_key;
   logic [IdxW-1:0]    rd_age;
   logic [BYTES_W-1:0] rd_bytes;
   logic [IdxW-1:0]    new_age;
   logic [IdxW-1:0]    top_age;
   row_ctrl_type       ctrl;
   row_stat_type       stat;
   logic               last;
   logic               evict_go;
   logic [USED_W-1:0]  old_bytes_ext;
   logic [31:0]        prod;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // slab size from the request
   assign prod = req_tdata[63:48] * req_tdata[47:32];

   // read the table one row per cycle during a sweep
   assign rd_en    = (state_ff == ST_PASS) && (cnt_ff != CntW'(SLOTS));
   assign rd_key   = key_type'(rd_data[KEY_W-1:0]);
   assign rd_age   = rd_data[KEY_W +: IdxW];
   assign rd_bytes = rd_data[KEY_W+IdxW +: BYTES_W];
   assign top_age  = IdxW'(n_ff - CntW'(1));
   assign last     = p_vld_ff && (p_idx_ff == IdxW'(SLOTS - 1));

   assign ctrl.mode   = mode_ff;
   assign ctrl.target = (p_idx_ff == tgt_idx_ff);

   assign wr_data = stat.use_new ? {new_bytes_ff, {IdxW{1'b0}}, key_ff}
                                 : {rd_bytes, new_age, rd_key};

   lbbc_ram #(
      .Width (RowW),
      .Depth (SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (p_idx_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[IdxW-1:0]),
      .rd_data (rd_data)
   );

   lbbc_row_unit #(
      .AgeW (IdxW)
   ) u_row (
      .row_valid (valid_ff[p_idx_ff]),
      .row_key   (rd_key),
      .row_age   (rd_age),
      .req_key   (key_ff),
      .ref_age   (ref_age_ff),
      .top_age   (top_age),
      .ctrl      (ctrl),
      .stat      (stat),
      .new_age   (new_age)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      cnt_in       = cnt_ff;
      p_vld_in     = rd_en;
      p_idx_in     = cnt_ff[IdxW-1:0];
      valid_in     = valid_ff;
      n_in         = n_ff;
      cap_in       = cap_ff;
      used_in      = used_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      evs_in       = evs_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_tready;
      key_in       = key_ff;
      new_bytes_in = new_bytes_ff;
      hit_in       = hit_ff;
      ev_now_in    = ev_now_ff;
      found_in     = found_ff;
      free_seen_in = free_seen_ff;
      free_idx_in  = free_idx_ff;
      tgt_idx_in   = tgt_idx_ff;
      ref_age_in   = ref_age_ff;
      old_idx_in   = old_idx_ff;
      old_bytes_in = old_bytes_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      evict_go     = 1'b0;

      if (csr_wen) begin
         cap_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               key_in       = key_type'(req_tdata[KEY_W-1:0]);
               new_bytes_in = {1'b0, prod, 1'b0};
               hit_in       = 1'b0;
               ev_now_in    = '0;
               unique case (req_tuser)
                  OP_LOOKUP: begin
                     state_in     = ST_PASS;
                     mode_in      = MODE_SCAN;
                     cnt_in       = '0;
                     found_in     = 1'b0;
                     free_seen_in = 1'b0;
                  end
                  OP_DECODE: begin
                     misses_in = misses_ff + 1'b1;
                     state_in  = ST_FIN;
                  end
                  OP_CLEAR: begin
                     valid_in = '0;
                     used_in  = '0;
                     n_in     = '0;
                     state_in = ST_FIN;
                  end
                  OP_STATS: begin
                     hits_in   = '0;
                     misses_in = '0;
                     evs_in    = '0;
                     state_in  = ST_FIN;
                  end
               endcase
            end
         end

         ST_PASS: begin
            if (rd_en) begin
               cnt_in = cnt_ff + 1'b1;
            end
            // work on the row read last cycle
            if (p_vld_ff) begin
               unique case (mode_ff)
                  MODE_SCAN: begin
                     if (stat.match && !found_ff) begin
                        found_in   = 1'b1;
                        tgt_idx_in = p_idx_ff;
                        ref_age_in = rd_age;
                     end
                     if (!valid_ff[p_idx_ff] && !free_seen_ff) begin
                        free_seen_in = 1'b1;
                        free_idx_in  = p_idx_ff;
                     end
                     if (stat.oldest) begin
                        old_idx_in   = p_idx_ff;
                        old_bytes_in = rd_bytes;
                     end
                  end
                  MODE_HIT: begin
                     ram_we = stat.wr_en;
                  end
                  MODE_INS: begin
                     ram_we = stat.wr_en;
                     if (stat.use_new) begin
                        valid_in[p_idx_ff] = 1'b1;
                     end
                  end
                  MODE_FIND: begin
                     if (stat.oldest) begin
                        old_idx_in   = p_idx_ff;
                        old_bytes_in = rd_bytes;
                     end
                  end
               endcase
            end
            // close the sweep and pick what follows
            if (last) begin
               cnt_in = '0;
               unique case (mode_ff)
                  MODE_SCAN: begin
                     if (found_in) begin
                        hits_in = hits_ff + 1'b1;
                        hit_in  = 1'b1;
                        mode_in = MODE_HIT;
                     end else begin
                        misses_in = misses_ff + 1'b1;
                        mode_in   = MODE_INS;
                        if (n_ff == CntW'(SLOTS)) begin
                           evict_go   = 1'b1;
                           tgt_idx_in = old_idx_in;
                        end else begin
                           tgt_idx_in = free_idx_in;
                        end
                     end
                  end
                  MODE_HIT: begin
                     state_in = ST_FIN;
                  end
                  MODE_INS: begin
                     n_in     = n_ff + 1'b1;
                     used_in  = used_ff + USED_W'(new_bytes_ff);
                     state_in = ST_CHECK;
                  end
                  MODE_FIND: begin
                     evict_go = 1'b1;
                     state_in = ST_CHECK;
                  end
               endcase
            end
         end

         ST_CHECK: begin
            if ((used_ff > USED_W'(cap_ff)) && (n_ff != '0)) begin
               state_in = ST_PASS;
               mode_in  = MODE_FIND;
               cnt_in   = '0;
            end else begin
               state_in = ST_FIN;
            end
         end

         ST_FIN: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {4'b0, evs_ff, misses_ff, hits_ff, used_ff[CAP_W-1:0],
                              EVN_W'(ev_now_ff), hit_ff};
               state_in    = ST_IDLE;
            end
         end
      endcase

      // drop the oldest entry and release its bytes
      if (evict_go) begin
         valid_in[old_idx_in] = 1'b0;
         used_in   = (used_ff >= old_bytes_ext) ? used_ff - old_bytes_ext : '0;
         evs_in    = evs_ff + 1'b1;
         ev_now_in = ev_now_ff + 1'b1;
         n_in      = n_ff - 1'b1;
      end
   end

   assign old_bytes_ext = USED_W'(old_bytes_in);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         mode_ff    <= MODE_SCAN;
         cnt_ff     <= '0;
         p_vld_ff   <= 1'b0;
         valid_ff   <= '0;
         n_ff       <= '0;
         cap_ff     <= CAP_RESET;
         used_ff    <= '0;
         hits_ff    <= '0;
         misses_ff  <= '0;
         evs_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         mode_ff    <= mode_in;
         cnt_ff     <= cnt_in;
         p_vld_ff   <= p_vld_in;
         valid_ff   <= valid_in;
         n_ff       <= n_in;
         cap_ff     <= cap_in;
         used_ff    <= used_in;
         hits_ff    <= hits_in;
         misses_ff  <= misses_in;
         evs_ff     <= evs_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      p_idx_ff     <= p_idx_in;
      key_ff       <= key_in;
      new_bytes_ff <= new_bytes_in;
      hit_ff       <= hit_in;
      ev_now_ff    <= ev_now_in;
      found_ff     <= found_in;
      free_seen_ff <= free_seen_in;
      free_idx_ff  <= free_idx_in;
      tgt_idx_ff   <= tgt_idx_in;
      ref_age_ff   <= ref_age_in;
      old_idx_ff   <= old_idx_in;
      old_bytes_ff <= old_bytes_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

`default_nettype wire

[bench/lru_byte_budget_cache_test.sv]
module lru_byte_budget_cache_test;
   import lbbc_pkg::*;

   localparam int SLOT_COUNT  = 16;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 45;
   localparam int POOL_KEYS   = 24;
   localparam int LONG_HOLD   = 300;
   localparam int DRAIN_WAIT  = 2 * SLOT_COUNT + 8;
   localparam int CYCLE_LIMIT = 800000;
   localparam logic [CAP_W-1:0] CAP_MAX = 38'd137438953472;

   // one response word, fields as they appear on rsp_tdata
   typedef struct packed {
      logic             hit;
      logic [EVN_W-1:0] evicted;
      logic [CAP_W-1:0] bytes;
      logic [CNT_W-1:0] hits;
      logic [CNT_W-1:0] misses;
      logic [CNT_W-1:0] evictions;
   } rsp_type;

   // one row of the directed table; a typed row carries its known response
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [15:0]     tensor;
      logic [15:0]     start;
      logic [15:0]     count;
      logic [15:0]     rows;
      logic [7:0]      reps;
      logic            typed;
      rsp_type         known;
   } dir_row_type;

   // one cached slab of the shadow table
   typedef struct {
      key_type     key;
      logic [63:0] bytes;
   } slab_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wen;
   logic [CAP_W-1:0]      csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [OP_W-1:0]       req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // shadow table in recency order, index 0 most recent
   slab_type         lru_order[$];
   logic [63:0]      used_sum;
   logic [CAP_W-1:0] budget;
   logic [CNT_W-1:0] hit_cnt;
   logic [CNT_W-1:0] miss_cnt;
   logic [CNT_W-1:0] evict_cnt;

   rsp_type     awaited[$];
   dir_row_type directed_rows [12];
   key_type     key_pool [POOL_KEYS];
   int          errors;
   int          hold_requests;
   bit          quiet;

   lru_byte_budget_cache #(.SLOTS(SLOT_COUNT)) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // drop the least recent slab and count it
   function automatic void drop_oldest();
      slab_type s;
      s = lru_order.pop_back();
      used_sum = (used_sum >= s.bytes) ? used_sum - s.bytes : 64'd0;
      evict_cnt = evict_cnt + 1'b1;
   endfunction

   // advance the shadow table by one request and return the response it gives
   function automatic rsp_type cache_step(logic [OP_W-1:0] op, key_type k, logic [15:0] rows);
      rsp_type  r;
      slab_type s;
      int       pos;
      r = '0;
      pos = -1;
      case (op)
         OP_LOOKUP: begin
            foreach (lru_order[i])
               if (pos < 0 && lru_order[i].key == k) pos = i;
            if (pos >= 0) begin
               s = lru_order[pos];
               lru_order.delete(pos);
               lru_order.insert(0, s);
               hit_cnt = hit_cnt + 1'b1;
               r.hit = 1'b1;
            end else begin
               miss_cnt = miss_cnt + 1'b1;
               // full table: make room first
               if (lru_order.size() >= SLOT_COUNT) begin
                  drop_oldest();
                  r.evicted = r.evicted + 1'b1;
               end
               s.key = k;
               s.bytes = 64'(rows) * 64'(k.count) * 64'd2;
               lru_order.insert(0, s);
               used_sum = used_sum + s.bytes;
               // walk the budget, the new slab may go too
               while (used_sum > 64'(budget) && lru_order.size() > 0) begin
                  drop_oldest();
                  r.evicted = r.evicted + 1'b1;
               end
            end
         end
         OP_DECODE: miss_cnt = miss_cnt + 1'b1;
         OP_CLEAR: begin
            lru_order.delete();
            used_sum = 64'd0;
         end
         default: begin
            hit_cnt = '0;
            miss_cnt = '0;
            evict_cnt = '0;
         end
      endcase
      r.bytes = used_sum[CAP_W-1:0];
      r.hits = hit_cnt;
      r.misses = miss_cnt;
      r.evictions = evict_cnt;
      return r;
   endfunction

   // offer one word and hold it until accepted; return its predicted response
   task automatic send_word(input logic [OP_W-1:0] op, input key_type k,
                            input logic [15:0] rows, output rsp_type predicted);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {rows, k.count, k.start, k.tensor};
      do @(posedge clock); while (!req_tready);
      predicted = cache_step(op, k, rows);
   endtask

   // drop valid for a short burst now and then
   task automatic sender_pause();
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // write the budget once the block has gone idle
   task automatic program_budget(input logic [CAP_W-1:0] value);
      while (awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      budget = value;
   endtask

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   // compare each accepted response word with the oldest prediction
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited.size() == 0) begin
            $error("response word with no request outstanding");
            errors++;
         end else begin
            want = awaited.pop_front();
            check_field("hit", 64'(want.hit), 64'(rsp_tdata[0]));
            check_field("evicted_now", 64'(want.evicted), 64'(rsp_tdata[5:1]));
            check_field("bytes_in_use", 64'(want.bytes), 64'(rsp_tdata[43:6]));
            check_field("hit_total", 64'(want.hits), 64'(rsp_tdata[75:44]));
            check_field("miss_total", 64'(want.misses), 64'(rsp_tdata[107:76]));
            check_field("eviction_total", 64'(want.evictions), 64'(rsp_tdata[139:108]));
         end
      end
   end

   // receiver: random stall bursts, plus a long hold on request
   initial begin : rsp_side
      int hold_served;
      hold_served = 0;
      rsp_tready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_served != hold_requests) begin
            hold_served++;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // watchdog
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      rsp_type          got;
      key_type          k;
      logic [15:0]      rows;
      logic [OP_W-1:0]  op;
      logic [CAP_W-1:0] cap_next;
      int               sel;

      reset = 1'b1;
      csr_wen = 1'b0;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_LOOKUP;
      errors = 0;
      hold_requests = 0;
      quiet = 1'b0;
      used_sum = 64'd0;
      budget = CAP_RESET;
      hit_cnt = '0;
      miss_cnt = '0;
      evict_cnt = '0;

      directed_rows = '{
         // decode only: one miss, nothing cached
         '{OP_DECODE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd1, 1'b1,
           '{1'b0, 5'd0, 38'd0, 32'd0, 32'd1, 32'd0}},
         // zero-size slab goes in
         '{OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd1, 1'b1,
           '{1'b0, 5'd0, 38'd0, 32'd0, 32'd2, 32'd0}},
         // same key, other row count: still a hit
         '{OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 8'd1, 1'b1,
           '{1'b1, 5'd0, 38'd0, 32'd1, 32'd2, 32'd0}},
         // oversize slab flushes the table and itself
         '{OP_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd1, 1'b1,
           '{1'b0, 5'd2, 38'd0, 32'd1, 32'd3, 32'd2}},
         '{OP_STATS, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd1, 1'b1, '0},
         '{OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd1, 1'b1, '0},
         '{OP_LOOKUP, 16'h1234, 16'h0040, 16'h0100, 16'h0020, 8'd1, 1'b0, '0},
         '{OP_LOOKUP, 16'h1234, 16'h0040, 16'h0101, 16'h0003, 8'd1, 1'b0, '0},
         '{OP_LOOKUP, 16'h1234, 16'h0040, 16'h0100, 16'h0007, 8'd1, 1'b0, '0},
         '{OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd1, 1'b0, '0},
         // fill every slot, then one more pushes out the oldest
         '{OP_LOOKUP, 16'h0100, 16'h8000, 16'h0010, 16'h0010, 8'd17, 1'b0, '0},
         '{OP_LOOKUP, 16'h0101, 16'h8000, 16'h0010, 16'h0001, 8'd1, 1'b0, '0}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, run at the reset budget
      foreach (directed_rows[i]) begin
         for (int r = 0; r < directed_rows[i].reps; r++) begin
            k.tensor = directed_rows[i].tensor + 16'(r);
            k.start = directed_rows[i].start;
            k.count = directed_rows[i].count;
            sender_pause();
            send_word(directed_rows[i].op, k, directed_rows[i].rows, got);
            awaited.push_back(directed_rows[i].typed ? directed_rows[i].known : got);
         end
      end
      req_tvalid <= 1'b0;

      // random phases, each under its own budget
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       cap_next = '0;
            1, 8:    cap_next = CAP_MAX;
            3:       cap_next = CAP_RESET;
            4:       cap_next = (38'($urandom_range(0, 31)) << 32) | 38'($urandom);
            6:       cap_next = 38'd1;
            default: cap_next = 38'($urandom_range(20000000, 60000000));
         endcase
         program_budget(cap_next);
         // small key pool so slabs come back and hit
         foreach (key_pool[j]) begin
            key_pool[j].tensor = 16'($urandom);
            key_pool[j].start = 16'($urandom);
            key_pool[j].count = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
         end
         quiet = (p == PHASES - 1);
         if (p == 2) hold_requests++;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            sel = $urandom_range(0, 99);
            rows = ($urandom_range(0, 99) < 15) ? 16'($urandom)
                                                : 16'($urandom_range(0, 63));
            k = key_pool[$urandom_range(0, POOL_KEYS - 1)];
            op = OP_LOOKUP;
            if (sel >= 93) begin
               k.tensor = 16'($urandom);
               k.start = 16'($urandom);
               k.count = 16'($urandom);
               rows = 16'($urandom);
            end else if (sel >= 90) begin
               op = OP_STATS;
            end else if (sel >= 86) begin
               op = OP_CLEAR;
            end else if (sel >= 80) begin
               op = OP_DECODE;
            end
            sender_pause();
            send_word(op, k, rows, got);
            awaited.push_back(got);
         end
         req_tvalid <= 1'b0;
      end

      // drain, then let the block settle
      while (awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
